FILE: rtl/ksw_pkg.sv
// Package for the keyed score window: request codes, field widths, controller states, divider command struct.
// No dependencies.
`default_nettype none
package ksw_pkg;
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_EVAL   = 2'd2,
      REQ_FIND   = 2'd3
   } req_op_type;

   localparam int SCORE_BITS = 17;
   localparam int TICK_BITS  = 64;
   localparam int SUM_BITS   = 30;
   localparam logic [SCORE_BITS-1:0] SCORE_ONE = 17'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DIV,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   dividend;
      logic [7:0]            divisor;
   } div_cmd_type;
endpackage
`default_nettype wire

FILE: rtl/ksw_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
`default_nettype none
interface ksw_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ksw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ksw_pkg.
`default_nettype none
module ksw_div
   import ksw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_cmd_type           cmd,
   output logic                       done,
   output logic [SUM_BITS-1:0]        quotient
);
   logic [SUM_BITS-1:0] q_ff, q_in;
   logic [7:0]          rem_ff, rem_in;
   logic [7:0]          dvs_ff, dvs_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [8:0]          trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[SUM_BITS-1]};
      if (cmd.start) begin
         q_in = cmd.dividend; rem_in = '0; dvs_in = cmd.divisor;
         cnt_in = 5'(SUM_BITS - 1); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 8'(trial - {1'b0, dvs_ff});
            q_in = {q_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            q_in = {q_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

FILE: rtl/keyed_score_window_top.sv
// Keyed score window top level: record store, scan sequencer, divider.
// Depends on ksw_pkg, ksw_if, ksw_div.
`default_nettype none
// Records sit in a circular store with one registered read port, scanned one
// record per cycle for evaluate and find; remove passes a wait state after each
// dropped record. One item is worked on at a time: req.ready is low from
// acceptance until the result has been taken, and rises again in the cycle after.
// Insert writes its record on acceptance; remove drops records from the oldest
// end while their tick lies below the request tick; find scans from the newest
// record back to the oldest, stopping at the first match; evaluate scans every
// record and, when a record matched, then runs the bit-serial divider.
module keyed_score_window_top
   import ksw_pkg::*;
#(
   parameter int WINDOW_DEPTH = 208,
   parameter int KEY_BITS     = 8
)(
   input  wire logic clock,
   input  wire logic reset,
   ksw_if.sink       req,
   ksw_if.source     rsp
);
   localparam int PB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CB = $clog2(WINDOW_DEPTH + 1);
   localparam int RW = KEY_BITS + SCORE_BITS + TICK_BITS;

   // request payload: req_type, key_id, score_in, score_invalid, tick_value, threshold
   logic [1:0]            req_type;
   logic [7:0]            req_key_id;
   logic [17:0]           req_score_in;
   logic                  req_score_invalid;
   logic [63:0]           req_tick_value;
   logic [16:0]           req_threshold;
   assign {req_type, req_key_id, req_score_in, req_score_invalid, req_tick_value,
           req_threshold} = req.data;

   logic [RW-1:0] mem [WINDOW_DEPTH];
   logic [RW-1:0] rd_ff;
   logic [PB-1:0] rd_addr;
   logic          wr_en;
   logic [PB-1:0] wr_addr;
   logic [RW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   logic [KEY_BITS-1:0]   rd_key;
   logic [SCORE_BITS-1:0] rd_score;
   logic [TICK_BITS-1:0]  rd_tick;
   assign {rd_key, rd_score, rd_tick} = rd_ff;

   ctl_state_type st_ff, st_in;
   req_op_type    op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [16:0]           thr_ff, thr_in;
   logic [PB-1:0]         old_ff, old_in;
   logic [CB-1:0]         fill_ff, fill_in;
   logic [CB-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [7:0]            cnt_ff, cnt_in, drop_ff, drop_in;
   logic                  hit_ff, hit_in;
   logic [SCORE_BITS-1:0] hs_ff, hs_in;
   logic [TICK_BITS-1:0]  ht_ff, ht_in;
   logic [SCORE_BITS-1:0] mean_ff, mean_in;
   logic                  ov_ff, ov_in;
   logic [SCORE_BITS-1:0] clamped;
   logic [CB:0]           slot_sum;
   logic [PB-1:0]         slot;
   logic [CB-1:0]         age;
   div_cmd_type           dcmd;
   logic                  ddone;
   logic [SUM_BITS-1:0]   dq;

   ksw_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .done(ddone),
                  .quotient(dq));

   always_comb begin
      if (req_score_invalid || req_score_in[17]) clamped = '0;
      else if (req_score_in[16:0] > SCORE_ONE) clamped = SCORE_ONE;
      else clamped = req_score_in[16:0];
   end

   // record age addressed this cycle
   always_comb begin
      age = idx_ff;
      if (st_ff == ST_IDLE) age = fill_ff;
      else if (st_ff == ST_SCAN && op_ff == REQ_REMOVE) age = '0;
      else if (st_ff == ST_SCAN && op_ff != REQ_EVAL) age = CB'(idx_ff - 1'b1);
   end

   always_comb begin
      slot_sum = (CB+1)'(old_ff) + (CB+1)'(age);
      if (slot_sum >= (CB+1)'(WINDOW_DEPTH)) slot = PB'(slot_sum - (CB+1)'(WINDOW_DEPTH));
      else slot = PB'(slot_sum);
   end

   always_comb begin
      st_in = st_ff; op_in = op_ff; key_in = key_ff; tick_in = tick_ff; thr_in = thr_ff;
      old_in = old_ff; fill_in = fill_ff; idx_in = idx_ff; pend_in = 1'b0;
      sum_in = sum_ff; cnt_in = cnt_ff; drop_in = drop_ff; hit_in = hit_ff;
      hs_in = hs_ff; ht_in = ht_ff; mean_in = mean_ff; ov_in = ov_ff;
      wr_en = 1'b0; wr_addr = slot; wr_data = '0;
      dcmd = '0; rd_addr = slot;
      req.ready = (st_ff == ST_IDLE) && !ov_ff;
      if (rsp.ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req_op_type'(req_type);
               key_in = req_key_id[KEY_BITS-1:0];
               tick_in = req_tick_value; thr_in = req_threshold;
               sum_in = '0; cnt_in = '0; drop_in = '0; hit_in = 1'b0;
               hs_in = '0; ht_in = '0; mean_in = '0;
               case (req_op_type'(req_type))
                  REQ_INSERT: begin
                     wr_en = 1'b1;
                     wr_data = {req_key_id[KEY_BITS-1:0], clamped, req_tick_value};
                     if (fill_ff == CB'(WINDOW_DEPTH)) begin
                        wr_addr = old_ff;
                        old_in = (old_ff == PB'(WINDOW_DEPTH - 1)) ? '0 : PB'(old_ff + 1'b1);
                        drop_in = 8'd1;
                     end else fill_in = CB'(fill_ff + 1'b1);
                     st_in = ST_DONE;
                  end
                  REQ_REMOVE: begin
                     idx_in = '0; st_in = ST_SCAN;
                  end
                  REQ_EVAL: begin
                     idx_in = '0; st_in = ST_SCAN;
                  end
                  REQ_FIND: begin
                     idx_in = fill_ff; st_in = ST_SCAN;
                  end
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            // issue reads; pend_ff marks rd_ff valid for the previous address
            case (op_ff)
               REQ_REMOVE: begin
                  rd_addr = old_ff;
                  if (pend_ff) begin
                     if (rd_tick < tick_ff) begin
                        old_in = (old_ff == PB'(WINDOW_DEPTH - 1)) ? '0 : PB'(old_ff + 1'b1);
                        fill_in = CB'(fill_ff - 1'b1);
                        drop_in = drop_ff + 8'd1;
                        st_in = ST_WAIT;
                     end else st_in = ST_DONE;
                  end else if (fill_ff == '0) st_in = ST_DONE;
                  else pend_in = 1'b1;
               end
               REQ_EVAL: begin
                  if (pend_ff && rd_key == key_ff) begin
                     sum_in = sum_ff + SUM_BITS'(rd_score);
                     cnt_in = cnt_ff + 8'd1;
                  end
                  if (idx_ff == fill_ff) begin
                     if (pend_ff) st_in = ST_WAIT;
                     else st_in = ST_DIV;
                  end else begin
                     pend_in = 1'b1; idx_in = CB'(idx_ff + 1'b1);
                  end
               end
               default: begin
                  if (pend_ff && rd_key == key_ff) begin
                     hit_in = 1'b1; hs_in = rd_score; ht_in = rd_tick; st_in = ST_DONE;
                  end else if (idx_ff == '0) st_in = ST_DONE;
                  else begin
                     pend_in = 1'b1; idx_in = CB'(idx_ff - 1'b1);
                  end
               end
            endcase
         end
         ST_WAIT: begin
            if (op_ff == REQ_REMOVE) st_in = ST_SCAN;
            else begin
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) st_in = ST_DONE;
            else if (!pend_ff && !ddone) begin
               dcmd.start = 1'b1; dcmd.dividend = sum_ff; dcmd.divisor = cnt_ff;
               pend_in = 1'b1;
            end else if (ddone) begin
               mean_in = SCORE_BITS'(dq); st_in = ST_DONE;
            end else pend_in = 1'b1;
         end
         ST_DONE: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   logic [123:0] out_ff, out_in;
   always_comb begin
      out_in = out_ff;
      if (st_ff == ST_DONE && (!ov_ff || rsp.ready))
         out_in = {(op_ff == REQ_EVAL) && ({1'b0, mean_ff} >= {1'b0, thr_ff}),
                   (op_ff == REQ_EVAL) ? mean_ff : SCORE_BITS'(0),
                   (op_ff == REQ_EVAL) ? cnt_ff : 8'd0,
                   hit_ff, hs_ff, ht_ff,
                   (op_ff == REQ_INSERT || op_ff == REQ_REMOVE) ? drop_ff : 8'd0,
                   8'(fill_ff)};
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; tick_ff <= tick_in; thr_ff <= thr_in;
      idx_ff <= idx_in; sum_ff <= sum_in; cnt_ff <= cnt_in; drop_ff <= drop_in;
      hit_ff <= hit_in; hs_ff <= hs_in; ht_ff <= ht_in; mean_ff <= mean_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; old_ff <= '0; fill_ff <= '0; pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; old_ff <= old_in; fill_ff <= fill_in; pend_ff <= pend_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;
endmodule
`default_nettype wire
